[sv/ipfr_pkg.sv]
// Shared types and status codes for the IPv4 fragment reassembly tracker.
`default_nettype none
package ipfr_pkg;

  typedef enum logic [3:0] {
    ST_PENDING    = 4'd0,
    ST_COMPLETE   = 4'd1,
    ST_DUPLICATE  = 4'd2,
    ST_MALFORMED  = 4'd3,
    ST_OVERSIZE   = 4'd4,
    ST_TABLE_FULL = 4'd5,
    ST_LIST_FULL  = 4'd6,
    ST_EXPIRED    = 4'd7,
    ST_TICK_DONE  = 4'd8
  } status_t;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_SCAN     = 12'b000000000010,
    S_CHECK    = 12'b000000000100,
    S_WALK_RD  = 12'b000000001000,
    S_WALK_CHK = 12'b000000010000,
    S_DECIDE   = 12'b000000100000,
    S_SHIFT_RD = 12'b000001000000,
    S_SHIFT_WR = 12'b000010000000,
    S_INSERT   = 12'b000100000000,
    S_FINAL    = 12'b001000000000,
    S_EMIT     = 12'b010000000000,
    S_TICK     = 12'b100000000000
  } state_t;

  localparam logic [15:0] TTL_AT_RESET  = 16'd600;
  localparam logic [16:0] MAX_DGRAM_LEN = 17'd65535;
  localparam logic [16:0] SIZE_MAX17    = 17'h1FFFF;
  localparam logic [1:0]  FL_FIRST      = 2'b01;
  localparam logic [1:0]  FL_LAST       = 2'b10;

endpackage
`default_nettype wire

[sv/ipfr_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ipfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/ip_fragment_reassembly_tracker_unit.sv]
// Top level of the IPv4 fragment reassembly tracker: context table, list walker, ticker.
// A fragment beat runs the table scan, check, list walk, decide, list shift, insert, final and
// emit states; the list walk and list shift go through the single fragment RAM read port.
// A tick beat scans every slot and emits one result for each expiry, or one done result.
// One beat is worked at a time; in_ready is high only while idle, and output stalls hold the emit state.
// Synchronous reset empties the context table, clears the output valid and loads a TTL of 600.
`default_nettype none
module ip_fragment_reassembly_tracker_unit #(
  parameter int NUM_CONTEXTS      = 16,
  parameter int FRAGS_PER_CONTEXT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [15:0] datagram_id,
  input  wire logic [31:0] src_addr,
  input  wire logic [31:0] dst_addr,
  input  wire logic [7:0]  protocol,
  input  wire logic [15:0] frag_offset,
  input  wire logic [5:0]  header_len,
  input  wire logic [15:0] total_len,
  input  wire logic        more_fragments,
  input  wire logic [15:0] tick_delta,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       status,
  output logic [3:0]       context_slot,
  output logic [15:0]      reassembled_len,
  output logic [5:0]       datagram_header_len,
  output logic             last
);
  import ipfr_pkg::*;

  localparam int SW    = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int CW    = $clog2(FRAGS_PER_CONTEXT + 1);
  localparam int DEPTH = NUM_CONTEXTS * FRAGS_PER_CONTEXT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_CONTEXTS - 1);
  localparam logic [CW-1:0] FRAGS_C   = CW'(FRAGS_PER_CONTEXT);
  localparam logic [AW-1:0] FRAGS_A   = AW'(FRAGS_PER_CONTEXT);

  // Context table, read at the slot register and written at it or at the newly opened slot.
  logic          ctx_valid         [NUM_CONTEXTS];
  logic [15:0]   ctx_ident         [NUM_CONTEXTS];
  logic [31:0]   ctx_source        [NUM_CONTEXTS];
  logic [31:0]   ctx_dest          [NUM_CONTEXTS];
  logic [7:0]    ctx_proto         [NUM_CONTEXTS];
  logic [15:0]   ctx_ttl           [NUM_CONTEXTS];
  logic [5:0]    ctx_hdr_len       [NUM_CONTEXTS];
  logic [16:0]   ctx_expected_size [NUM_CONTEXTS];
  logic [16:0]   ctx_received_size [NUM_CONTEXTS];
  logic [1:0]    ctx_edge_flags    [NUM_CONTEXTS];
  logic [CW-1:0] ctx_frag_count    [NUM_CONTEXTS];

  state_t        state;
  logic [15:0]   initial_ttl;
  logic [SW-1:0] slot;
  logic [SW-1:0] free_idx;
  logic          free_found;
  logic          tick_mode;
  logic          tick_fin;
  logic          have_pend;
  logic [SW-1:0] pend_slot;

  // Latched request fields.
  logic [15:0] r_id;
  logic [31:0] r_src;
  logic [31:0] r_dst;
  logic [7:0]  r_proto;
  logic [15:0] r_off;
  logic [5:0]  r_hlen;
  logic [15:0] r_tlen;
  logic        r_mf;
  logic [15:0] r_delta;

  // List walk and shift.
  logic [CW-1:0] wi;
  logic [CW-1:0] si;
  logic [CW-1:0] pos;
  logic          has_pred;
  logic [31:0]   pred;

  // Result staged for the output register.
  logic [3:0]  res_status;
  logic [3:0]  res_slot;
  logic [15:0] res_len;
  logic [5:0]  res_hl;
  logic        res_last;

  logic          cur_valid;
  logic          key_hit;
  logic          cur_full;
  logic [15:0]   pay;
  logic [16:0]   overlap_end;
  logic [17:0]   rec_sum;
  logic [17:0]   dgram_len;
  logic [AW-1:0] slot_base;
  logic [CW-1:0] rd_idx;
  logic          out_free;
  logic [SW-1:0] open_slot;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  assign cur_valid = ctx_valid[slot];
  assign key_hit   = cur_valid && (ctx_ident[slot] == r_id) && (ctx_proto[slot] == r_proto)
                     && (ctx_source[slot] == r_src) && (ctx_dest[slot] == r_dst);
  assign cur_full  = (ctx_edge_flags[slot] == (FL_FIRST | FL_LAST))
                     && (ctx_received_size[slot] == ctx_expected_size[slot]);
  assign pay         = r_tlen - {10'd0, r_hlen};
  assign overlap_end = {1'b0, pred[31:16]} + {1'b0, pred[15:0]};
  assign rec_sum     = {1'b0, ctx_received_size[slot]} + {2'd0, pay};
  assign dgram_len   = {12'd0, ctx_hdr_len[slot]} + {1'b0, ctx_expected_size[slot]};
  assign slot_base   = AW'(slot) * FRAGS_A;
  assign rd_idx      = ((state == S_SHIFT_RD) ? si : wi) - CW'(1);
  assign out_free    = !out_valid || out_ready;
  assign open_slot   = free_found ? free_idx : slot;

  assign in_ready  = (state == S_IDLE);
  assign ram_raddr = slot_base + AW'(rd_idx);
  assign ram_we    = (state == S_SHIFT_WR) || (state == S_INSERT);
  assign ram_waddr = slot_base + AW'((state == S_SHIFT_WR) ? si : pos);
  assign ram_wdata = (state == S_SHIFT_WR) ? ram_rdata : {r_off, pay};

  ipfr_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_frag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      initial_ttl <= TTL_AT_RESET;
      out_valid   <= 1'b0;
      tick_mode   <= 1'b0;
      for (int k = 0; k < NUM_CONTEXTS; k++) begin
        ctx_valid[k] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        initial_ttl <= cfg_wdata;
      end
      // The emit state decides the output valid on its own.
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_id       <= datagram_id;
            r_src      <= src_addr;
            r_dst      <= dst_addr;
            r_proto    <= protocol;
            r_off      <= frag_offset;
            r_hlen     <= header_len;
            r_tlen     <= total_len;
            r_mf       <= more_fragments;
            r_delta    <= tick_delta;
            slot       <= '0;
            free_found <= 1'b0;
            tick_mode  <= req_type;
            tick_fin   <= 1'b0;
            have_pend  <= 1'b0;
            state      <= req_type ? S_TICK : S_SCAN;
          end
        end

        // One slot per cycle; the first match wins, else the lowest free slot opens.
        S_SCAN: begin
          if (key_hit) begin
            state <= S_CHECK;
          end else begin
            if (!cur_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= slot;
            end
            if (slot == LAST_SLOT) begin
              if (free_found || !cur_valid) begin
                slot                         <= open_slot;
                ctx_valid[open_slot]         <= 1'b1;
                ctx_ident[open_slot]         <= r_id;
                ctx_source[open_slot]        <= r_src;
                ctx_dest[open_slot]          <= r_dst;
                ctx_proto[open_slot]         <= r_proto;
                ctx_ttl[open_slot]           <= initial_ttl;
                ctx_hdr_len[open_slot]       <= '0;
                ctx_expected_size[open_slot] <= '0;
                ctx_received_size[open_slot] <= '0;
                ctx_edge_flags[open_slot]    <= '0;
                ctx_frag_count[open_slot]    <= '0;
                state                        <= S_CHECK;
              end else begin
                res_status <= ST_TABLE_FULL;
                res_slot   <= '0;
                res_len    <= '0;
                res_hl     <= '0;
                res_last   <= 1'b1;
                state      <= S_EMIT;
              end
            end else begin
              slot <= slot + SW'(1);
            end
          end
        end

        S_CHECK: begin
          res_slot <= 4'(slot);
          res_len  <= '0;
          res_hl   <= '0;
          res_last <= 1'b1;
          has_pred <= 1'b0;
          if (r_tlen < {10'd0, r_hlen}) begin
            res_status <= ST_MALFORMED;
            state      <= S_EMIT;
          end else if (ctx_frag_count[slot] >= FRAGS_C) begin
            res_status <= ST_LIST_FULL;
            state      <= S_EMIT;
          end else if (!r_mf) begin
            if (ctx_edge_flags[slot][1]) begin
              res_status <= ST_DUPLICATE;
              state      <= S_EMIT;
            end else begin
              // The last fragment goes to the tail without further checks.
              ctx_edge_flags[slot]    <= ctx_edge_flags[slot] | FL_LAST;
              ctx_expected_size[slot] <= {1'b0, r_off} + {1'b0, pay};
              pos                     <= ctx_frag_count[slot];
              state                   <= S_INSERT;
            end
          end else begin
            wi <= ctx_frag_count[slot];
            if (ctx_frag_count[slot] == '0) begin
              pos   <= '0;
              state <= S_DECIDE;
            end else begin
              state <= S_WALK_RD;
            end
          end
        end

        S_WALK_RD: begin
          state <= S_WALK_CHK;
        end

        S_WALK_CHK: begin
          if (r_off == ram_rdata[31:16]) begin
            res_status <= ST_DUPLICATE;
            state      <= S_EMIT;
          end else if (r_off > ram_rdata[31:16]) begin
            pos      <= wi;
            has_pred <= 1'b1;
            pred     <= ram_rdata;
            state    <= S_DECIDE;
          end else if (wi == CW'(1)) begin
            pos   <= '0;
            state <= S_DECIDE;
          end else begin
            wi    <= wi - CW'(1);
            state <= S_WALK_RD;
          end
        end

        S_DECIDE: begin
          si <= ctx_frag_count[slot];
          if ((ctx_hdr_len[slot] != '0) && (ctx_hdr_len[slot] != r_hlen)) begin
            res_status <= ST_MALFORMED;
            state      <= S_EMIT;
          end else begin
            ctx_hdr_len[slot] <= r_hlen;
            if (has_pred && (overlap_end > {1'b0, r_off})) begin
              res_status <= ST_MALFORMED;
              state      <= S_EMIT;
            end else begin
              if (r_off == '0) begin
                ctx_edge_flags[slot] <= ctx_edge_flags[slot] | FL_FIRST;
              end
              state <= (ctx_frag_count[slot] > pos) ? S_SHIFT_RD : S_INSERT;
            end
          end
        end

        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end

        // The RAM write of this cycle moves entry si-1 up to si.
        S_SHIFT_WR: begin
          si    <= si - CW'(1);
          state <= ((si - CW'(1)) > pos) ? S_SHIFT_RD : S_INSERT;
        end

        S_INSERT: begin
          ctx_frag_count[slot]    <= ctx_frag_count[slot] + CW'(1);
          ctx_received_size[slot] <= (rec_sum > {1'b0, SIZE_MAX17}) ? SIZE_MAX17
                                                                     : rec_sum[16:0];
          state                   <= S_FINAL;
        end

        S_FINAL: begin
          if (cur_full) begin
            ctx_valid[slot] <= 1'b0;
            if (dgram_len > {1'b0, MAX_DGRAM_LEN}) begin
              res_status <= ST_OVERSIZE;
            end else begin
              res_status <= ST_COMPLETE;
              res_len    <= dgram_len[15:0];
              res_hl     <= ctx_hdr_len[slot];
            end
          end else begin
            res_status <= ST_PENDING;
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            status              <= res_status;
            context_slot        <= res_slot;
            reassembled_len     <= res_len;
            datagram_header_len <= res_hl;
            last                <= res_last;
            state               <= tick_mode ? S_TICK : S_IDLE;
          end
        end

        // An expiry is held back one step so the final one can carry last.
        S_TICK: begin
          res_len <= '0;
          res_hl  <= '0;
          if (tick_fin) begin
            res_status <= have_pend ? ST_EXPIRED : ST_TICK_DONE;
            res_slot   <= have_pend ? 4'(pend_slot) : 4'd0;
            res_last   <= 1'b1;
            tick_mode  <= 1'b0;
            state      <= S_EMIT;
          end else begin
            if (slot == LAST_SLOT) begin
              tick_fin <= 1'b1;
            end else begin
              slot <= slot + SW'(1);
            end
            if (cur_valid && !cur_full) begin
              if (ctx_ttl[slot] <= r_delta) begin
                ctx_valid[slot] <= 1'b0;
                have_pend       <= 1'b1;
                pend_slot       <= slot;
                if (have_pend) begin
                  res_status <= ST_EXPIRED;
                  res_slot   <= 4'(pend_slot);
                  res_last   <= 1'b0;
                  state      <= S_EMIT;
                end
              end else begin
                ctx_ttl[slot] <= ctx_ttl[slot] - r_delta;
              end
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb_ip_fragment_reassembly_tracker_unit.sv]
// Testbench for the IPv4 fragment reassembly tracker: predicts every result beat and checks it.
`default_nettype none

// Scoreboard: a behavioral copy of the context table plus a queue of expected result beats.
class reasm_scoreboard;
  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  slot;
    logic [15:0] rlen;
    logic [5:0]  hlen;
    logic        last;
  } result_t;

  result_t     pending_results[$];
  int          errors;
  logic [15:0] ttl_setting;
  bit          valid_q[16];
  logic [15:0] id_q[16];
  logic [31:0] src_q[16];
  logic [31:0] dst_q[16];
  logic [7:0]  proto_q[16];
  logic [16:0] ttl_q[16];
  logic [5:0]  hdr_q[16];
  logic [16:0] exp_q[16];
  logic [16:0] rcv_q[16];
  logic [1:0]  flags_q[16];
  int          cnt_q[16];
  logic [15:0] offs_q[16][16];
  logic [15:0] pays_q[16][16];

  function new();
    errors = 0;
    ttl_setting = ipfr_pkg::TTL_AT_RESET;
    foreach (valid_q[i]) valid_q[i] = 1'b0;
  endfunction

  function void push(ipfr_pkg::status_t st, int slot, int rlen, int hl, bit lst);
    result_t r;
    r.status = st;
    r.slot = slot[3:0];
    r.rlen = rlen[15:0];
    r.hlen = hl[5:0];
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  function bit done_ctx(int c);
    return flags_q[c] == (ipfr_pkg::FL_FIRST | ipfr_pkg::FL_LAST) && rcv_q[c] == exp_q[c];
  endfunction

  // Notes one accepted input beat and queues the result beats it causes.
  function void note_input(bit is_tick, logic [15:0] id, logic [31:0] src,
                           logic [31:0] dst, logic [7:0] pro, logic [15:0] off,
                           logic [5:0] hl, logic [15:0] tl, bit mf, logic [15:0] delta);
    int c, pos, n, i;
    bit found, pred;
    int pay;
    int sum;
    if (is_tick) begin
      n = 0;
      for (c = 0; c < 16; c++) begin
        if (!valid_q[c] || done_ctx(c)) continue;
        if (ttl_q[c] <= {1'b0, delta}) begin
          valid_q[c] = 1'b0;
          push(ipfr_pkg::ST_EXPIRED, c, 0, 0, 1'b0);
          n++;
        end else begin
          ttl_q[c] = ttl_q[c] - {1'b0, delta};
        end
      end
      if (n == 0) push(ipfr_pkg::ST_TICK_DONE, 0, 0, 0, 1'b1);
      else pending_results[$].last = 1'b1;
      return;
    end
    found = 1'b0;
    for (c = 0; c < 16; c++)
      if (valid_q[c] && id_q[c] == id && proto_q[c] == pro && src_q[c] == src &&
          dst_q[c] == dst) begin
        found = 1'b1;
        break;
      end
    if (!found) begin
      for (c = 0; c < 16; c++) if (!valid_q[c]) break;
      if (c >= 16) begin
        push(ipfr_pkg::ST_TABLE_FULL, 0, 0, 0, 1'b1);
        return;
      end
      valid_q[c] = 1'b1; id_q[c] = id; src_q[c] = src; dst_q[c] = dst; proto_q[c] = pro;
      ttl_q[c] = {1'b0, ttl_setting}; hdr_q[c] = '0; exp_q[c] = '0; rcv_q[c] = '0;
      flags_q[c] = '0; cnt_q[c] = 0;
    end
    if (tl < {10'd0, hl}) begin
      push(ipfr_pkg::ST_MALFORMED, c, 0, 0, 1'b1);
      return;
    end
    pay = int'(tl) - int'(hl);
    if (cnt_q[c] >= 16) begin
      push(ipfr_pkg::ST_LIST_FULL, c, 0, 0, 1'b1);
      return;
    end
    if (!mf) begin
      if ((flags_q[c] & ipfr_pkg::FL_LAST) != 2'b00) begin
        push(ipfr_pkg::ST_DUPLICATE, c, 0, 0, 1'b1);
        return;
      end
      flags_q[c] |= ipfr_pkg::FL_LAST;
      exp_q[c] = 17'(int'(off) + pay);
      pos = cnt_q[c];
    end else begin
      pred = 1'b0;
      pos = 0;
      for (i = cnt_q[c]; i > 0; i--) begin
        if (off == offs_q[c][i-1]) begin
          push(ipfr_pkg::ST_DUPLICATE, c, 0, 0, 1'b1);
          return;
        end
        if (off > offs_q[c][i-1]) begin
          pos = i;
          pred = 1'b1;
          break;
        end
      end
      if (hdr_q[c] != 6'd0 && hdr_q[c] != hl) begin
        push(ipfr_pkg::ST_MALFORMED, c, 0, 0, 1'b1);
        return;
      end
      hdr_q[c] = hl;
      if (pred && int'(offs_q[c][pos-1]) + int'(pays_q[c][pos-1]) > int'(off)) begin
        push(ipfr_pkg::ST_MALFORMED, c, 0, 0, 1'b1);
        return;
      end
      if (off == 16'd0) flags_q[c] |= ipfr_pkg::FL_FIRST;
    end
    for (i = cnt_q[c]; i > pos; i--) begin
      offs_q[c][i] = offs_q[c][i-1];
      pays_q[c][i] = pays_q[c][i-1];
    end
    offs_q[c][pos] = off;
    pays_q[c][pos] = 16'(pay);
    cnt_q[c]++;
    sum = int'(rcv_q[c]) + pay;
    rcv_q[c] = (sum > 131071) ? 17'h1FFFF : sum[16:0];
    if (done_ctx(c)) begin
      valid_q[c] = 1'b0;
      sum = int'(hdr_q[c]) + int'(exp_q[c]);
      if (sum > 65535) push(ipfr_pkg::ST_OVERSIZE, c, 0, 0, 1'b1);
      else push(ipfr_pkg::ST_COMPLETE, c, sum, int'(hdr_q[c]), 1'b1);
      return;
    end
    push(ipfr_pkg::ST_PENDING, c, 0, 0, 1'b1);
  endfunction

  // Checks one accepted result beat against the oldest expectation.
  function void check_result(logic [3:0] st, logic [3:0] slot, logic [15:0] rlen,
                             logic [5:0] hl, logic lst);
    result_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result beat status %0d slot %0d", $time, st, slot);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (st !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, st); errors++;
    end
    if (slot !== e.slot) begin
      $display("%0t: context_slot expected %0d actual %0d", $time, e.slot, slot); errors++;
    end
    if (rlen !== e.rlen) begin
      $display("%0t: reassembled_len expected %0d actual %0d", $time, e.rlen, rlen);
      errors++;
    end
    if (hl !== e.hlen) begin
      $display("%0t: datagram_header_len expected %0d actual %0d", $time, e.hlen, hl);
      errors++;
    end
    if (lst !== e.last) begin
      $display("%0t: last expected %0d actual %0d", $time, e.last, lst); errors++;
    end
  endfunction
endclass

module tb_ip_fragment_reassembly_tracker_unit;
  import ipfr_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [15:0] datagram_id;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [7:0]  protocol;
  logic [15:0] frag_offset;
  logic [5:0]  header_len;
  logic [15:0] total_len;
  logic        more_fragments;
  logic [15:0] tick_delta;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  status;
  logic [3:0]  context_slot;
  logic [15:0] reassembled_len;
  logic [5:0]  datagram_header_len;
  logic        last;

  // Percent chances that the sender and the receiver sit idle in a given cycle.
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count = 0;
  reasm_scoreboard reasm_sb;

  ip_fragment_reassembly_tracker_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .datagram_id(datagram_id), .src_addr(src_addr), .dst_addr(dst_addr),
    .protocol(protocol), .frag_offset(frag_offset), .header_len(header_len),
    .total_len(total_len), .more_fragments(more_fragments), .tick_delta(tick_delta),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .context_slot(context_slot), .reassembled_len(reassembled_len),
    .datagram_header_len(datagram_header_len), .last(last)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // The run ends here on a hang; the limit covers the slowest legal run many times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver stalls at random, and every accepted result beat goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      reasm_sb.check_result(status, context_slot, reassembled_len, datagram_header_len, last);
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Drives one input beat, holding it steady until the block takes it.
  task automatic send_beat(bit is_tick, logic [15:0] id, logic [31:0] src,
                           logic [31:0] dst, logic [7:0] pro, logic [15:0] off,
                           logic [5:0] hl, logic [15:0] tl, bit mf, logic [15:0] delta);
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    in_valid <= 1'b1;
    req_type <= is_tick; datagram_id <= id; src_addr <= src; dst_addr <= dst;
    protocol <= pro; frag_offset <= off; header_len <= hl; total_len <= tl;
    more_fragments <= mf; tick_delta <= delta;
    do @(posedge clk); while (!in_ready);
    reasm_sb.note_input(is_tick, id, src, dst, pro, off, hl, tl, mf, delta);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_frag(logic [15:0] id, logic [31:0] src, logic [15:0] off,
                           logic [5:0] hl, logic [15:0] tl, bit mf);
    send_beat(1'b0, id, src, 32'h0a000001, 8'd17, off, hl, tl, mf, 16'd0);
  endtask

  task automatic send_tick(logic [15:0] delta);
    send_beat(1'b1, 16'd0, 32'd0, 32'd0, 8'd0, 16'd0, 6'd20, 16'd20, 1'b0, delta);
  endtask

  // Waits until every expected beat has come, then lets a tick or table scan drain.
  task automatic drain();
    while (reasm_sb.pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_ttl(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    reasm_sb.ttl_setting = v;
  endtask

  // A well-formed datagram of n pieces in shuffled order, with optional damage.
  task automatic send_datagram(logic [15:0] id, logic [31:0] src, int n, bit broken);
    int order[$];
    int i, j, tmp, unit;
    logic [5:0] hl;
    hl = 6'(20 + 4 * $urandom_range(10));
    unit = 8 * $urandom_range(1, 40);
    for (i = 0; i < n; i++) order.push_back(i);
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    foreach (order[k]) begin
      if (broken && $urandom_range(3) == 0)
        send_frag(id, src, 16'(order[k] * unit + 8 * $urandom_range(2)),
                  6'(20 + 4 * $urandom_range(10)), 16'($urandom_range(60, 400)),
                  1'($urandom_range(1)));
      else
        send_frag(id, src, 16'(order[k] * unit), hl, 16'(hl + unit), order[k] != n - 1);
    end
  endtask

  task automatic random_phase(int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0: begin
          send_tick($urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(60)));
          sent++;
        end
        1: begin
          send_beat(1'b0, 16'($urandom), $urandom, $urandom, 8'($urandom), 16'($urandom),
                    6'($urandom), 16'($urandom), 1'($urandom_range(1)), 16'($urandom));
          sent++;
        end
        default: begin
          n = $urandom_range(1, 5);
          send_datagram(16'($urandom_range(3)), $urandom_range(1), n, $urandom_range(4) == 0);
          sent += n;
        end
      endcase
    end
  endtask

  initial begin
    int i;
    reasm_sb = new();
    rst = 1; cfg_we = 0; cfg_wdata = 0; in_valid = 0;
    req_type = 0; datagram_id = 0; src_addr = 0; dst_addr = 0; protocol = 0;
    frag_offset = 0; header_len = 20; total_len = 20; more_fragments = 0; tick_delta = 0;
    send_idle_pct = 16;
    recv_idle_pct = 46;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed part: completion, duplicates, malformed cases, full list and table.
    send_frag(16'hffff, 32'hffffffff, 16'd0, 6'd60, 16'd100, 1'b1);
    send_frag(16'hffff, 32'hffffffff, 16'd40, 6'd60, 16'd100, 1'b0);
    send_frag(16'd1, 32'd0, 16'd0, 6'd20, 16'd65535, 1'b1);
    send_frag(16'd1, 32'd0, 16'd65528, 6'd20, 16'd65535, 1'b0);
    send_frag(16'd2, 32'd0, 16'd8, 6'd20, 16'd10, 1'b1);
    send_frag(16'd2, 32'd0, 16'd8, 6'd20, 16'd60, 1'b1);
    send_frag(16'd2, 32'd0, 16'd16, 6'd24, 16'd60, 1'b1);
    send_frag(16'd2, 32'd0, 16'd0, 6'd20, 16'd60, 1'b1);
    send_frag(16'd2, 32'd0, 16'd200, 6'd20, 16'd28, 1'b0);
    send_frag(16'd2, 32'd0, 16'd208, 6'd20, 16'd28, 1'b0);
    for (i = 0; i < 17; i++) send_frag(16'd3, 32'd0, 16'(8 * i + 8), 6'd20, 16'd28, 1'b1);
    for (i = 0; i < 15; i++) send_frag(16'(100 + i), 32'd0, 16'd0, 6'd20, 16'd28, 1'b1);
    send_tick(16'd0);
    send_tick(16'd65535);

    // TTL settings, among them both extremes, each followed by a random phase.
    write_ttl(16'd1);
    random_phase(50);
    write_ttl(16'd65535);
    random_phase(70);
    send_idle_pct = 46;
    recv_idle_pct = 16;
    write_ttl(16'd40);
    random_phase(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_ttl(16'd600);
    random_phase(100);
    drain();

    if (reasm_sb.errors == 0 && reasm_sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
sv/ipfr_pkg.sv
sv/ipfr_ram.sv
sv/ip_fragment_reassembly_tracker_unit.sv
tb/sv/tb_ip_fragment_reassembly_tracker_unit.sv
